// ----- hw/rtl/rhsl_pkg.sv -----
// Shared types and constants for the RGBA to HSLA pixel converter.
// No dependencies; imported by every module of the block.
package rhsl_pkg;

   localparam int CH_W       = 8;
   localparam int QUO_W      = 8;    // quotient bits, one per divider cell
   localparam int SAT_REM_W  = 16;   // 255 * d
   localparam int SAT_DSH_W  = 15;   // den << 7
   localparam int HUE_REM_W  = 19;   // 255 * v, v < 1530
   localparam int HUE_DSH_W  = 18;   // 6d << 7
   localparam int PREP_STAGES = 3;
   localparam int LATENCY     = PREP_STAGES + QUO_W;

   // One request as it travels down the divider row
   typedef struct packed {
      logic                 valid;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_DSH_W-1:0] sat_dsh;
      logic [QUO_W-1:0]     sat_quo;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_DSH_W-1:0] hue_dsh;
      logic [QUO_W-1:0]     hue_quo;
      logic [CH_W-1:0]      light;
      logic [CH_W-1:0]      alpha;
   } rhsl_lane_type;

endpackage

// ----- hw/rtl/rhsl_prep.sv -----
// Front end: max/min, sector, lightness and the two dividend/divisor pairs.
// Three register stages. Depends on rhsl_pkg.
module rhsl_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [rhsl_pkg::CH_W-1:0]  red,
   input  logic [rhsl_pkg::CH_W-1:0]  green,
   input  logic [rhsl_pkg::CH_W-1:0]  blue,
   input  logic [rhsl_pkg::CH_W-1:0]  alpha,
   output rhsl_pkg::rhsl_lane_type    lane_out
);
   import rhsl_pkg::*;

   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   // stage A
   logic              a_valid_ff, a_valid_in;
   logic [CH_W-1:0]   a_mx_ff, a_mx_in, a_mn_ff, a_mn_in, a_alpha_ff;
   logic signed [8:0] a_num_ff, a_num_in;
   logic [1:0]        a_sect_ff, a_sect_in;

   // stage B
   logic               b_valid_ff;
   logic [CH_W-1:0]    b_d_ff, b_d_in, b_alpha_ff;
   logic [8:0]         b_t_ff, b_t_in;
   logic signed [11:0] b_v_ff, b_v_in;
   logic [9:0]         b_kd;

   // stage C
   rhsl_lane_type      c_lane_ff, c_lane_in;
   logic [10:0]        c_six_d;
   logic signed [11:0] c_v_wrap;
   logic [10:0]        c_v;
   logic [7:0]         c_den;
   logic [8:0]         c_rest;
   logic               c_gray;

   always_comb begin
      a_valid_in = accept;
      a_mx_in = red;
      if (green > a_mx_in) a_mx_in = green;
      if (blue > a_mx_in) a_mx_in = blue;
      a_mn_in = red;
      if (green < a_mn_in) a_mn_in = green;
      if (blue < a_mn_in) a_mn_in = blue;
      if (a_mx_in == red) begin
         a_sect_in = SECT_RED;
         a_num_in  = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (a_mx_in == green) begin
         a_sect_in = SECT_GREEN;
         a_num_in  = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         a_sect_in = SECT_BLUE;
         a_num_in  = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      a_mx_ff    <= a_mx_in;
      a_mn_ff    <= a_mn_in;
      a_num_ff   <= a_num_in;
      a_sect_ff  <= a_sect_in;
      a_alpha_ff <= alpha;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_comb begin
      b_d_in = a_mx_ff - a_mn_ff;
      b_t_in = {1'b0, a_mx_ff} + {1'b0, a_mn_ff};
      case (a_sect_ff)
         SECT_RED:   b_kd = 10'd0;
         SECT_GREEN: b_kd = {1'b0, b_d_in, 1'b0};
         SECT_BLUE:  b_kd = {b_d_in, 2'b00};
         default:    b_kd = 10'd0;
      endcase
      b_v_in = $signed({2'b00, b_kd}) + 12'(a_num_ff);
   end

   always_ff @(posedge clock) begin
      b_d_ff     <= b_d_in;
      b_t_ff     <= b_t_in;
      b_v_ff     <= b_v_in;
      b_alpha_ff <= a_alpha_ff;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_comb begin
      c_gray   = (b_d_ff == '0);
      c_six_d  = 11'({b_d_ff, 2'b00}) + 11'({b_d_ff, 1'b0});
      c_v_wrap = b_v_ff[11] ? (b_v_ff + $signed({1'b0, c_six_d})) : b_v_ff;
      c_v      = c_v_wrap[10:0];
      c_rest   = 9'd510 - b_t_ff;
      c_den    = b_t_ff[8] ? c_rest[7:0] : b_t_ff[7:0];
      if (b_t_ff == 9'd256) c_den = c_rest[7:0];   // 510 - 256 = 254

      c_lane_in.valid   = b_valid_ff;
      c_lane_in.sat_rem = {b_d_ff, 8'h00} - SAT_REM_W'(b_d_ff);
      c_lane_in.hue_rem = {c_v, 8'h00} - HUE_REM_W'(c_v);
      // grey pixel: dividends are zero, a unit divisor keeps the quotients zero
      c_lane_in.sat_dsh = c_gray ? SAT_DSH_W'(1) << (QUO_W - 1)
                                 : SAT_DSH_W'(c_den) << (QUO_W - 1);
      c_lane_in.hue_dsh = c_gray ? HUE_DSH_W'(1) << (QUO_W - 1)
                                 : HUE_DSH_W'(c_six_d) << (QUO_W - 1);
      c_lane_in.sat_quo = '0;
      c_lane_in.hue_quo = '0;
      c_lane_in.light   = b_t_ff[8:1];
      c_lane_in.alpha   = b_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_lane_ff <= '0;
      end else begin
         c_lane_ff <= c_lane_in;
      end
   end

   assign lane_out = c_lane_ff;

endmodule

// ----- hw/rtl/rhsl_div_cell.sv -----
// One restoring-division cell: settles one quotient bit of saturation and hue.
// Depends on rhsl_pkg.
module rhsl_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rhsl_pkg::rhsl_lane_type lane_in,
   output rhsl_pkg::rhsl_lane_type lane_out
);
   import rhsl_pkg::*;

   rhsl_lane_type lane_ff, lane_nx_in;
   logic          sat_ge, hue_ge;

   always_comb begin
      sat_ge = lane_in.sat_rem >= SAT_REM_W'(lane_in.sat_dsh);
      hue_ge = lane_in.hue_rem >= HUE_REM_W'(lane_in.hue_dsh);

      lane_nx_in         = lane_in;
      lane_nx_in.sat_rem = sat_ge ? lane_in.sat_rem - SAT_REM_W'(lane_in.sat_dsh)
                                  : lane_in.sat_rem;
      lane_nx_in.hue_rem = hue_ge ? lane_in.hue_rem - HUE_REM_W'(lane_in.hue_dsh)
                                  : lane_in.hue_rem;
      lane_nx_in.sat_dsh = lane_in.sat_dsh >> 1;
      lane_nx_in.hue_dsh = lane_in.hue_dsh >> 1;
      lane_nx_in.sat_quo = {lane_in.sat_quo[QUO_W-2:0], sat_ge};
      lane_nx_in.hue_quo = {lane_in.hue_quo[QUO_W-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_nx_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ----- hw/rtl/rgb_to_hsl_pixel_top.sv -----
// RGBA to HSLA pixel converter, 8 bits per channel, fully pipelined.
// Request channel: drive req_* and pulse start; a request is taken at any edge
// where start is high and busy is low. busy is always low, so a new pixel may
// be offered on every clock.
// Response channel: rsp_strobe is high for one cycle with rsp_hue,
// rsp_saturation, rsp_lightness and rsp_alpha_out; the receiver cannot stall,
// so it must take the response in that cycle.
// The response passes 3 front-end stages, then a row of 8 divider cells, one
// quotient bit each for saturation and hue. Throughput: one pixel per clock.
// Responses come out in request order.
// Reset (synchronous, active high) empties the pipeline; requests in flight
// are dropped and no response appears for them.
// Depends on rhsl_pkg, rhsl_prep and rhsl_div_cell.
module rgb_to_hsl_pixel_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_alpha_in,
   output logic       rsp_strobe,
   output logic [7:0] rsp_hue,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_lightness,
   output logic [7:0] rsp_alpha_out
);
   import rhsl_pkg::*;

   rhsl_lane_type lanes [0:QUO_W];
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rhsl_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .alpha    (req_alpha_in),
      .lane_out (lanes[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      rhsl_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lanes[i]),
         .lane_out (lanes[i+1])
      );
   end

   assign rsp_strobe     = lanes[QUO_W].valid;
   assign rsp_hue        = lanes[QUO_W].hue_quo;
   assign rsp_saturation = lanes[QUO_W].sat_quo;
   assign rsp_lightness  = lanes[QUO_W].light;
   assign rsp_alpha_out  = lanes[QUO_W].alpha;

   // a response only ever follows a request taken a fixed latency earlier
   a_strobe_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without matching request");

   // v stays below 6d, so hue tops out at 254
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_hue != 8'hFF)
      else $error("hue out of range");

   // zero saturation only for a grey pixel, whose hue is zero too
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturation == 8'h00) |-> rsp_hue == 8'h00)
      else $error("grey pixel with nonzero hue");

endmodule
